[rtl/core/assert_macros.svh]
// Assertion macros shared by the centered moving average RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CMA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cma assertion failed");

// Condition that must never be true outside reset.
`define CMA_NEVER(label, clk, rst_n, expr) \
    `CMA_ASSERT(label, clk, rst_n, !(expr))

`endif

[rtl/core/cma_pkg.sv]
// Package for the centered moving average core: widths, limits and the
// structs passed between the sequencer, the divider and the top level.
package cma_pkg;

    localparam int DATA_W         = 16;
    localparam int WL_W           = 6;
    localparam int HALF_W         = WL_W - 1;
    localparam int RING_DEPTH_DEF = 64;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

    // One result word from the sequencer.
    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic signed [DATA_W-1:0] average;
    } t_res;

    // Divider request: start strobe and the filter length.
    typedef struct packed {
        logic            start;
        logic [WL_W-1:0] divisor;
    } t_div_req;

    // Divider response: saturated quotient, valid while done is high.
    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [DATA_W-1:0] quotient;
    } t_div_rsp;

endpackage

[rtl/core/cma_smp_if.sv]
// Input sample channel of the centered moving average core.
// Depends on cma_pkg.
interface cma_smp_if;
    import cma_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample;
    logic                     last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

[rtl/core/cma_avg_if.sv]
// Result channel of the centered moving average core.
// Depends on cma_pkg.
interface cma_avg_if;
    import cma_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] average;
    logic                     last_result;

    modport source (output valid, output average, output last_result, input ready);
    modport sink   (input valid, input average, input last_result, output ready);
endinterface

[rtl/core/cma_cfg_if.sv]
// Configuration write channel carrying the window length.
// Depends on cma_pkg.
interface cma_cfg_if;
    import cma_pkg::*;

    logic            valid;
    logic            ready;
    logic [WL_W-1:0] window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

[rtl/core/cma_ring_mem.sv]
// Sample ring storage: one write port, one read port, registered read data.
// Depends on cma_pkg for the sample width.
module cma_ring_mem #(
    parameter int DEPTH = cma_pkg::RING_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [AW-1:0]                    i_waddr,
    input  logic signed [cma_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]                    i_raddr,
    output logic signed [cma_pkg::DATA_W-1:0] o_rdata
);
    import cma_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: the read data is registered and appears in the cycle after its address.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/cma_div.sv]
// Iterative restoring divider: signed window sum by the unsigned filter
// length, truncated toward zero and saturated to 16 bits. Depends on cma_pkg.
module cma_div #(
    parameter int NUM_W = 23
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  cma_pkg::t_div_req       i_req,
    input  logic signed [NUM_W-1:0] i_dividend,
    output cma_pkg::t_div_rsp       o_rsp
);
    import cma_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_fin;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_neg;
    logic [WL_W-1:0]   r_rem;
    logic [NUM_W-1:0]  r_q;
    logic [WL_W-1:0]   r_dvs;

    logic [NUM_W-1:0]  mag_in;
    logic [WL_W:0]     rem_sh;
    logic [WL_W:0]     rem_diff;
    logic              rem_ge;
    logic [WL_W-1:0]   rem_nxt;
    logic signed [DATA_W-1:0] quot;

    // Magnitude of the dividend; the most negative value maps correctly.
    assign mag_in = i_dividend[NUM_W-1] ? NUM_W'(-i_dividend) : NUM_W'(i_dividend);

    // One quotient bit per cycle.
    assign rem_sh   = {r_rem, r_q[NUM_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_dvs};
    assign rem_diff = rem_sh - {1'b0, r_dvs};
    assign rem_nxt  = rem_ge ? rem_diff[WL_W-1:0] : rem_sh[WL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_dividend[NUM_W-1];
                r_q    <= mag_in;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= rem_nxt;
                r_q   <= {r_q[NUM_W-2:0], rem_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // Restore the sign and saturate to the sample range.
    always_comb begin
        if (r_neg) begin
            if (r_q > NUM_W'(32768)) begin
                quot = SAT_MIN;
            end else begin
                quot = ~r_q[DATA_W-1:0] + 16'd1;
            end
        end else begin
            if (r_q > NUM_W'(32767)) begin
                quot = SAT_MAX;
            end else begin
                quot = r_q[DATA_W-1:0];
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_fin;
    assign o_rsp.quotient = quot;
endmodule

[rtl/core/cma_ctrl.sv]
// Sequencer of the centered moving average: writes samples into the ring,
// walks each window through the memory read port and drives the divider.
// Depends on cma_pkg, cma_ring_mem's timing and assert_macros.svh.
`include "assert_macros.svh"

module cma_ctrl #(
    parameter int RING_DEPTH = cma_pkg::RING_DEPTH_DEF,
    parameter int AW         = $clog2(RING_DEPTH),
    parameter int SUM_W      = cma_pkg::DATA_W + $clog2(RING_DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [cma_pkg::WL_W-1:0]          i_window_length,
    input  logic                              i_smp_valid,
    output logic                              o_smp_ready,
    input  logic signed [cma_pkg::DATA_W-1:0] i_sample,
    input  logic                              i_last_sample,
    output cma_pkg::t_res                     o_res,
    input  logic                              i_res_ready,
    output logic                              o_mem_we,
    output logic [AW-1:0]                     o_mem_waddr,
    output logic signed [cma_pkg::DATA_W-1:0] o_mem_wdata,
    output logic [AW-1:0]                     o_mem_raddr,
    input  logic signed [cma_pkg::DATA_W-1:0] i_mem_rdata,
    output cma_pkg::t_div_req                 o_div_req,
    output logic signed [SUM_W-1:0]           o_div_dividend,
    input  cma_pkg::t_div_rsp                 i_div_rsp
);
    import cma_pkg::*;

    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int XW = ((AW > HALF_W) ? AW : HALF_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_START,
        S_FIRST,
        S_SUM,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [AW-1:0]           r_head;
    logic [CW-1:0]           r_seen;
    logic                    r_first_done;
    logic [WL_W-1:0]         r_div;
    logic [HALF_W-1:0]       r_half;
    logic                    r_last;
    logic                    r_flushing;
    logic [AW-1:0]           r_o;
    logic [AW-1:0]           r_far;
    logic [AW-1:0]           r_d;
    logic                    r_issuing;
    logic                    r_acc_vld;
    logic                    r_acc_last;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [DATA_W-1:0] r_avg;

    logic                    smp_acc;
    logic [WL_W-1:0]         cur_div;
    logic [XW-1:0]           o_plus_half;
    logic [XW-1:0]           seen_lim;
    logic [XW-1:0]           far_x;
    logic                    res_last;

    // Ring position that lies d samples behind the newest one.
    function automatic logic [AW-1:0] ring_idx(input logic [AW-1:0] head,
                                                input logic [AW-1:0] d);
        logic [AW+1:0] t;
        t = {2'b00, head} - {2'b00, d} - (AW+2)'(1);
        if (t[AW+1]) begin
            t = t + (AW+2)'(RING_DEPTH);
        end
        return t[AW-1:0];
    endfunction

    assign smp_acc     = i_smp_valid && (r_state == S_IDLE);
    assign o_smp_ready = (r_state == S_IDLE);
    assign cur_div     = (i_window_length == '0) ? WL_W'(1) : i_window_length;

    // Memory ports: samples are written at acceptance only, reads follow later.
    assign o_mem_we    = smp_acc;
    assign o_mem_waddr = r_head;
    assign o_mem_wdata = i_sample;
    assign o_mem_raddr = ring_idx(r_head, (r_state == S_SUM) ? r_d : r_o);

    // Far end of the window, clipped to the samples of this block.
    assign o_plus_half = XW'(r_o) + XW'(r_half);
    assign seen_lim    = XW'(r_seen) - XW'(1);
    assign far_x       = (o_plus_half < seen_lim) ? o_plus_half : seen_lim;

    // The final result of a block closes the flush, or stands alone for half 0.
    assign res_last = r_last && (r_flushing ? (r_o == '0) : (r_half == '0));

    assign o_res.valid   = (r_state == S_EMIT);
    assign o_res.last    = res_last;
    assign o_res.average = r_avg;

    assign o_div_req.start   = (r_state == S_DIV_GO);
    assign o_div_req.divisor = r_div;
    assign o_div_dividend    = r_sum;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_seen       <= '0;
            r_first_done <= 1'b0;
            r_issuing    <= 1'b0;
            r_acc_vld    <= 1'b0;
            r_acc_last   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (smp_acc) begin
                        r_head <= (r_head == AW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        if (r_seen != CW'(RING_DEPTH)) begin
                            r_seen <= r_seen + 1'b1;
                        end
                        r_div   <= cur_div;
                        r_half  <= cur_div[WL_W-1:1];
                        r_last  <= i_last_sample;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (XW'(r_seen) > XW'(r_half)) begin
                        r_o        <= AW'(r_half);
                        r_flushing <= 1'b0;
                        r_state    <= S_START;
                    end else if (r_last) begin
                        r_o        <= AW'(r_seen - CW'(1));
                        r_flushing <= 1'b1;
                        r_state    <= S_START;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_START: begin
                    // The read of the center sample is under way for the first output.
                    r_far      <= far_x[AW-1:0];
                    r_d        <= '0;
                    r_sum      <= '0;
                    r_acc_vld  <= 1'b0;
                    r_acc_last <= 1'b0;
                    if (!r_first_done) begin
                        r_state <= S_FIRST;
                    end else begin
                        r_issuing <= 1'b1;
                        r_state   <= S_SUM;
                    end
                end
                S_FIRST: begin
                    r_avg        <= i_mem_rdata;
                    r_first_done <= 1'b1;
                    r_state      <= S_EMIT;
                end
                S_SUM: begin
                    // One read issued and one word accumulated per cycle.
                    if (r_acc_vld) begin
                        r_sum <= r_sum + SUM_W'(i_mem_rdata);
                    end
                    r_acc_vld  <= r_issuing;
                    r_acc_last <= r_issuing && (r_d == r_far);
                    if (r_issuing) begin
                        if (r_d == r_far) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_d <= r_d + 1'b1;
                        end
                    end
                    if (r_acc_vld && r_acc_last) begin
                        r_state <= S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    r_acc_vld  <= 1'b0;
                    r_acc_last <= 1'b0;
                    r_state    <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_avg   <= i_div_rsp.quotient;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_res_ready) begin
                        if (r_flushing && (r_o != '0)) begin
                            r_o     <= r_o - 1'b1;
                            r_state <= S_START;
                        end else if (!r_flushing && r_last && (r_half != '0)) begin
                            r_o        <= AW'(r_half - HALF_W'(1));
                            r_flushing <= 1'b1;
                            r_state    <= S_START;
                        end else begin
                            if (r_last) begin
                                r_seen       <= '0;
                                r_first_done <= 1'b0;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A sample write never coincides with a window read.
    `CMA_NEVER(a_no_rw_overlap, i_clk, i_rst_n, o_mem_we && r_issuing)
    // The sample count saturates at the ring depth.
    `CMA_ASSERT(a_seen_range, i_clk, i_rst_n, r_seen <= CW'(RING_DEPTH))
    // The divider is only started when it is free.
    `CMA_NEVER(a_div_free, i_clk, i_rst_n, o_div_req.start && i_div_rsp.busy)
    // Handing over the final word of a block rewinds the block state.
    `CMA_ASSERT(a_block_end, i_clk, i_rst_n,
        (o_res.valid && i_res_ready && o_res.last) |=> (r_seen == '0 && !r_first_done))
endmodule

[rtl/core/centered_moving_average_core.sv]
// Channel   | Dir | Word                              | Handshake
// i_smp     | in  | sample (s16), last_sample         | valid/ready
// i_cfg     | in  | window_length (u6)                | valid/ready, always ready
// o_avg     | out | average (s16), last_result        | valid/ready, output register
//
// A sample with no result holds the input through the decide state. The first result
// of a block is a sample read straight from the ring, without the divider; any other
// result sums its window through the memory read port (one sample per cycle) and is
// then divided by the bit-serial divider over SUM_W bits (SUM_W = 23 at depth 64).
// Reset is synchronous, active low; the sample ring needs no clearing pass.
// A result waits in the output register while the next sample is taken.
module centered_moving_average_core #(
    parameter int RING_DEPTH = cma_pkg::RING_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cma_smp_if.sink        i_smp,
    cma_cfg_if.sink        i_cfg,
    cma_avg_if.source      o_avg
);
    import cma_pkg::*;

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int SUM_W = DATA_W + $clog2(RING_DEPTH + 1);

    logic [WL_W-1:0]          r_window_length;
    logic                     r_out_valid;
    logic                     r_out_last;
    logic signed [DATA_W-1:0] r_out_avg;

    t_res                     res;
    logic                     res_ready;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic signed [DATA_W-1:0] mem_rdata;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;
    logic signed [SUM_W-1:0]  div_dividend;

    // Configuration register.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WL_W'(1);
        end else if (i_cfg.valid) begin
            r_window_length <= i_cfg.window_length;
        end
    end

    // Output register: takes a new word when empty or being drained.
    assign res_ready = !r_out_valid || o_avg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_ready) begin
                r_out_valid <= res.valid;
            end
            if (res_ready && res.valid) begin
                r_out_avg  <= res.average;
                r_out_last <= res.last;
            end
        end
    end

    assign o_avg.valid       = r_out_valid;
    assign o_avg.average     = r_out_avg;
    assign o_avg.last_result = r_out_last;

    cma_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW),
        .SUM_W      (SUM_W)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_window_length (r_window_length),
        .i_smp_valid     (i_smp.valid),
        .o_smp_ready     (i_smp.ready),
        .i_sample        (i_smp.sample),
        .i_last_sample   (i_smp.last_sample),
        .o_res           (res),
        .i_res_ready     (res_ready),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_raddr     (mem_raddr),
        .i_mem_rdata     (mem_rdata),
        .o_div_req       (div_req),
        .o_div_dividend  (div_dividend),
        .i_div_rsp       (div_rsp)
    );

    cma_ring_mem #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    cma_div #(
        .NUM_W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .o_rsp      (div_rsp)
    );
endmodule
